// File: rtl/patan_pkg.sv
// Package for the fixed-point four-quadrant angle pipeline.
// Holds the field formats, polynomial coefficients, reflection constants
// and the octant flag word that travels down the pipeline. No dependencies.
package patan_pkg;

  localparam int INPUT_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_WIDTH     = 16;

  localparam int RATIO_FRAC = 15;
  localparam int QUO_BITS   = RATIO_FRAC + 1;
  localparam int NUM_W      = INPUT_WIDTH + RATIO_FRAC;

  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = QUO_BITS / DIV_BITS_PER_STAGE;

  localparam logic [15:0] COEF_C3 = 16'd1524;
  localparam logic [15:0] COEF_C2 = 16'd5220;
  localparam logic signed [16:0] COEF_C1 = 17'sd10736;

  localparam int R30_W = 36;
  localparam logic signed [R30_W-1:0] HALF_PI_Q30 = 36'sd1686629760;
  localparam logic signed [R30_W-1:0] PI_Q30      = 36'sd3373259520;
  localparam int OUT_SHIFT = 30 - ANGLE_FRAC_BITS;

  localparam logic signed [39:0] ANGLE_MAX = 40'sd32767;
  localparam logic signed [39:0] ANGLE_MIN = -40'sd32768;

  // Input register, divider stages, five polynomial stages, reflection, output.
  localparam int LATENCY = 1 + DIV_STAGES + 5 + 1 + 1;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic swap;
    logic zero;
  } oct_t;

endpackage

// File: rtl/polynomial_atan2_angle.sv
// Top level of the four-quadrant angle pipeline: ratio divider, minimax
// polynomial and octant reflection in one pipelined datapath.
// Depends on patan_pkg for formats, coefficients and the octant flag word.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+---------------------------------
//  input    | x_value, y_value          | word taken when start && !busy
//  result   | angle, both_zero          | one-cycle strobe on done
//
// A new word can enter in every cycle; busy is never raised.
// Each word passes the input register, eight stages of the restoring ratio
// divider (two quotient bits each), polynomial, reflection and output stages.
// Synchronous reset clears all stage valid bits; words in flight are dropped.
// The receiver cannot stall, so the pipeline advances on every clock.
module polynomial_atan2_angle import patan_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [INPUT_WIDTH-1:0] x_value,
  input  logic signed [INPUT_WIDTH-1:0] y_value,
  output logic                          done,
  output logic signed [ANGLE_WIDTH-1:0] angle,
  output logic                          both_zero
);

  function automatic logic signed [39:0] rnd_shift(input logic signed [39:0] v,
                                                   input int unsigned k);
    logic [39:0] mag;
    logic [39:0] half;
    mag  = v[39] ? 40'(-v) : 40'(v);
    half = 40'(1) << (k - 1);
    mag  = (mag + half) >> k;
    return v[39] ? -$signed(mag) : $signed(mag);
  endfunction

  assign busy = 1'b0;

  // Input stage: magnitudes, octant flags and the rounded dividend.
  logic [INPUT_WIDTH-1:0] x_mag, y_mag, mn_c, mx_c;
  logic [NUM_W-1:0]       num_c;
  oct_t                   fl_c;

  always_comb begin
    x_mag      = x_value[INPUT_WIDTH-1] ? (~x_value + 1'b1) : x_value;
    y_mag      = y_value[INPUT_WIDTH-1] ? (~y_value + 1'b1) : y_value;
    fl_c.swap  = y_mag > x_mag;
    fl_c.neg_x = x_value[INPUT_WIDTH-1];
    fl_c.neg_y = y_value[INPUT_WIDTH-1];
    mn_c       = fl_c.swap ? x_mag : y_mag;
    mx_c       = fl_c.swap ? y_mag : x_mag;
    fl_c.zero  = (mx_c == '0);
    num_c      = {mn_c, {RATIO_FRAC{1'b0}}} + NUM_W'(mx_c >> 1);
  end

  logic                   dv   [DIV_STAGES+1];
  oct_t                   dfl  [DIV_STAGES+1];
  logic [INPUT_WIDTH-1:0] dmx  [DIV_STAGES+1];
  logic [INPUT_WIDTH-1:0] drem [DIV_STAGES+1];
  logic [QUO_BITS-1:0]    dlow [DIV_STAGES+1];
  logic [QUO_BITS-1:0]    dquo [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dfl[0]  <= fl_c;
    dmx[0]  <= mx_c;
    drem[0] <= INPUT_WIDTH'(num_c[NUM_W-1:QUO_BITS]);
    dlow[0] <= num_c[QUO_BITS-1:0];
    dquo[0] <= '0;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [INPUT_WIDTH-1:0] rem_c;
    logic [QUO_BITS-1:0]    low_c;
    logic [QUO_BITS-1:0]    quo_c;

    always_comb begin
      logic [INPUT_WIDTH:0] trial;
      rem_c = drem[k];
      low_c = dlow[k];
      quo_c = dquo[k];
      for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
        trial = {rem_c, low_c[QUO_BITS-1]};
        low_c = low_c << 1;
        if (trial >= {1'b0, dmx[k]}) begin
          rem_c = INPUT_WIDTH'(trial - {1'b0, dmx[k]});
          quo_c = {quo_c[QUO_BITS-2:0], 1'b1};
        end else begin
          rem_c = trial[INPUT_WIDTH-1:0];
          quo_c = {quo_c[QUO_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      dfl[k+1]  <= dfl[k];
      dmx[k+1]  <= dmx[k];
      drem[k+1] <= rem_c;
      dlow[k+1] <= low_c;
      dquo[k+1] <= quo_c;
    end
  end

  // Polynomial stages.
  logic [15:0]        a_d;
  logic [31:0]        sq_c, m_c, ts_c;
  logic [15:0]        s_next, t_next;
  logic signed [16:0] u_next, p_next, w_c;
  logic signed [33:0] up_c, pa_c;
  logic signed [17:0] r_next;

  logic               v1, v2, v3, v4, v5, v6;
  oct_t               fl1, fl2, fl3, fl4, fl5;
  logic [15:0]        a1, a2, a3, a4;
  logic [15:0]        s1, s2, s3;
  logic [15:0]        t2;
  logic signed [16:0] u3, p4;
  logic signed [17:0] r5;

  assign a_d = dquo[DIV_STAGES];

  always_comb begin
    sq_c   = a_d * a_d;
    s_next = 16'((sq_c + 32'd16384) >> RATIO_FRAC);
    m_c    = COEF_C3 * s1;
    t_next = COEF_C2 - 16'((m_c + 32'd16384) >> RATIO_FRAC);
    ts_c   = t2 * s2;
    u_next = $signed({1'b0, 16'((ts_c + 32'd16384) >> RATIO_FRAC)}) - COEF_C1;
    up_c   = u3 * $signed({1'b0, s3});
    p_next = 17'(rnd_shift(40'(up_c), RATIO_FRAC));
    pa_c   = p4 * $signed({1'b0, a4});
    w_c    = 17'(rnd_shift(40'(pa_c), RATIO_FRAC));
    r_next = $signed({2'b00, a4}) + 18'(w_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= dv[DIV_STAGES];
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    fl1 <= dfl[DIV_STAGES];
    a1  <= a_d;
    s1  <= s_next;
    fl2 <= fl1;
    a2  <= a1;
    s2  <= s1;
    t2  <= t_next;
    fl3 <= fl2;
    a3  <= a2;
    s3  <= s2;
    u3  <= u_next;
    fl4 <= fl3;
    a4  <= a3;
    p4  <= p_next;
    fl5 <= fl4;
    r5  <= r_next;
  end

  // Octant reflection in Q.30.
  logic signed [R30_W-1:0] r30_c;
  logic signed [R30_W-1:0] r30_6;
  logic                    zero6;

  always_comb begin
    r30_c = R30_W'(r5) <<< RATIO_FRAC;
    if (fl5.swap) begin
      r30_c = HALF_PI_Q30 - r30_c;
    end
    if (fl5.neg_x) begin
      r30_c = PI_Q30 - r30_c;
    end
    if (fl5.neg_y) begin
      r30_c = -r30_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    r30_6 <= r30_c;
    zero6 <= fl5.zero;
  end

  // Output rounding and saturation.
  logic signed [39:0]            ang_c;
  logic signed [ANGLE_WIDTH-1:0] angle_next;

  always_comb begin
    ang_c = rnd_shift(40'(r30_6), OUT_SHIFT);
    if (zero6) begin
      angle_next = '0;
    end else if (ang_c > ANGLE_MAX) begin
      angle_next = ANGLE_WIDTH'(ANGLE_MAX);
    end else if (ang_c < ANGLE_MIN) begin
      angle_next = ANGLE_WIDTH'(ANGLE_MIN);
    end else begin
      angle_next = ANGLE_WIDTH'(ang_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
  end

  always_ff @(posedge clk) begin
    angle     <= angle_next;
    both_zero <= zero6;
  end

  a_result_follows_word: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word produced no result at the expected cycle");

  a_result_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching accepted word");

  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    (done && both_zero) |-> (angle == '0))
    else $error("zero input pair gave a nonzero angle");

  a_zero_flag_tracks_input: assert property (@(posedge clk) disable iff (rst)
    done |-> (both_zero == $past(x_value == '0 && y_value == '0, LATENCY)))
    else $error("zero flag does not match the accepted word");

endmodule

// File: sim/tb_polynomial_atan2_angle.sv
// Self-checking testbench for polynomial_atan2_angle: drives x/y words and
// compares each angle and zero flag with a fixed-point predictor.
// Depends on patan_pkg for the field widths and the pipeline latency.
module tb_polynomial_atan2_angle;
  timeunit 1ns;
  timeprecision 1ps;

  import patan_pkg::*;

  localparam int RANDOM_WORDS   = 1350;
  localparam int CALM_TAIL      = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DIRECTED_COUNT = 25;

  localparam int DIR_X [DIRECTED_COUNT] = '{
    0, 32767, -32768, 0, 0, 32767, -32768, -32768, 32767, 1, -1, 1, -1,
    -1, 0, 1, 0, 3, -3, 32767, 1, 100, -99, -32768, -21846
  };
  localparam int DIR_Y [DIRECTED_COUNT] = '{
    0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768, 1, -1, -1, 1,
    0, -1, 0, 1, 4, -4, 1, 32767, -99, 100, -1, -21846
  };

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] angle;
    logic                          both_zero;
  } angle_result_t;

  class angle_scoreboard;
    localparam longint C3          = 1524;
    localparam longint C2          = 5220;
    localparam longint C1          = 10736;
    localparam longint HALF_PI_R30 = 64'd1686629760;
    localparam longint PI_R30      = 64'd3373259520;
    localparam int     FRAC_BITS   = 13;

    angle_result_t expected_angles[$];
    int            failures = 0;
    int            reported = 0;

    function longint round_away(longint v, int k);
      longint half;
      half = longint'(1) <<< (k - 1);
      if (v >= 0) begin
        return (v + half) >>> k;
      end
      return -((-v + half) >>> k);
    endfunction

    function angle_result_t predict_angle(logic signed [INPUT_WIDTH-1:0] xv,
                                          logic signed [INPUT_WIDTH-1:0] yv);
      longint sx, sy, ax, ay, mn, mx, a, s, t, u, p, w, r30, ang;
      angle_result_t res;
      sx = xv;
      sy = yv;
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      mn = (ax < ay) ? ax : ay;
      mx = (ax < ay) ? ay : ax;
      if (mx == 0) begin
        res.angle     = '0;
        res.both_zero = 1'b1;
        return res;
      end
      a   = ((mn <<< 15) + (mx >>> 1)) / mx;
      s   = round_away(a * a, 15);
      t   = C2 - round_away(C3 * s, 15);
      u   = round_away(t * s, 15) - C1;
      p   = round_away(u * s, 15);
      w   = round_away(p * a, 15);
      r30 = (a + w) * 32768;
      if (ay > ax) r30 = HALF_PI_R30 - r30;
      if (sx < 0) r30 = PI_R30 - r30;
      if (sy < 0) r30 = -r30;
      ang = round_away(r30, 30 - FRAC_BITS);
      if (ang > 32767) ang = 32767;
      if (ang < -32768) ang = -32768;
      res.angle     = ang[ANGLE_WIDTH-1:0];
      res.both_zero = 1'b0;
      return res;
    endfunction

    function void note_word(logic signed [INPUT_WIDTH-1:0] xv,
                            logic signed [INPUT_WIDTH-1:0] yv);
      expected_angles.push_back(predict_angle(xv, yv));
    endfunction

    function void check_word(logic signed [ANGLE_WIDTH-1:0] ang, logic bz);
      angle_result_t exp;
      if (expected_angles.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("Unexpected result: angle %0d both_zero %0b", ang, bz);
        end
        return;
      end
      exp = expected_angles.pop_front();
      if (ang !== exp.angle || bz !== exp.both_zero) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("Mismatch: angle %0d both_zero %0b, expected angle %0d both_zero %0b",
                   ang, bz, exp.angle, exp.both_zero);
        end
      end
    endfunction

    function int pending();
      return expected_angles.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic signed [INPUT_WIDTH-1:0] x_value = '0;
  logic signed [INPUT_WIDTH-1:0] y_value = '0;
  logic                          done;
  logic signed [ANGLE_WIDTH-1:0] angle;
  logic                          both_zero;

  angle_scoreboard sb = new;
  int              stall_count = 0;

  polynomial_atan2_angle u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .x_value   (x_value),
    .y_value   (y_value),
    .done      (done),
    .angle     (angle),
    .both_zero (both_zero)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_word(x_value, y_value);
      if (done) sb.check_word(angle, both_zero);
      if ((start && !busy) || done) begin
        stall_count = 0;
      end else begin
        stall_count = stall_count + 1;
      end
    end
  end

  initial begin
    while (stall_count < WATCHDOG_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_word(logic signed [INPUT_WIDTH-1:0] xv,
                           logic signed [INPUT_WIDTH-1:0] yv);
    start   <= 1'b1;
    x_value <= xv;
    y_value <= yv;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic rest(int n);
    start   <= 1'b0;
    x_value <= INPUT_WIDTH'($urandom);
    y_value <= INPUT_WIDTH'($urandom);
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int                            i;
    logic signed [INPUT_WIDTH-1:0] xv, yv, mag;
    logic                          gaps_on;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_COUNT; i++) begin
      send_word(INPUT_WIDTH'(DIR_X[i]), INPUT_WIDTH'(DIR_Y[i]));
      if (i % 4 == 3) rest($urandom_range(1, 3));
    end

    for (i = 0; i < RANDOM_WORDS; i++) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          xv = INPUT_WIDTH'($urandom);
          yv = INPUT_WIDTH'($urandom);
        end
        2: begin
          xv = INPUT_WIDTH'(int'($urandom_range(0, 16)) - 8);
          yv = INPUT_WIDTH'(int'($urandom_range(0, 16)) - 8);
        end
        3: begin
          mag = INPUT_WIDTH'($urandom);
          xv  = $urandom_range(0, 1) ? mag : -mag;
          yv  = $urandom_range(0, 1) ? mag : -mag;
        end
        4: begin
          mag = INPUT_WIDTH'($urandom);
          xv  = INPUT_WIDTH'(int'($urandom_range(0, 64)) - 32);
          yv  = mag;
          if ($urandom_range(0, 1)) begin
            yv = xv;
            xv = mag;
          end
        end
        default: begin
          case ($urandom_range(0, 4))
            0: xv = 16'sh7fff;
            1: xv = 16'sh8000;
            2: xv = 16'sh0000;
            3: xv = 16'sh0001;
            default: xv = 16'shffff;
          endcase
          case ($urandom_range(0, 4))
            0: yv = 16'sh7fff;
            1: yv = 16'sh8000;
            2: yv = 16'sh0000;
            3: yv = 16'sh0001;
            default: yv = 16'shffff;
          endcase
        end
      endcase
      send_word(xv, yv);
      gaps_on = ((i / 100) % 2 == 0) && (i < RANDOM_WORDS - CALM_TAIL);
      if (gaps_on && $urandom_range(0, 3) == 0) rest($urandom_range(1, 3));
    end
    start <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/patan_pkg.sv
rtl/polynomial_atan2_angle.sv
sim/tb_polynomial_atan2_angle.sv
